### rtl/arp_reply_learning_cache_top_defines.svh
// Assertion macros shared by the ARP cache checker.
// No dependencies; include once per file that asserts.
`ifndef ARP_REPLY_LEARNING_CACHE_TOP_DEFINES_SVH
`define ARP_REPLY_LEARNING_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/arpc_pkg.sv
// Shared types, constants and helpers for the ARP reply learning cache.
// No dependencies.
package arpc_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OP_W      = 16;
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 56;

    localparam logic [OP_W-1:0] OP_REPLY = 16'h0002;

    localparam logic FUNC_LEARN  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] STAT_LOOKUP  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LEARNED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_RESOLVE
    } arpc_state_t;

    typedef struct packed {
        logic load_req;
        logic match;
        logic resolve;
    } arpc_cmd_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/arpc_ctrl.sv
// Sequencer for the ARP cache: accept, compare, resolve, hold result.
// Depends on arpc_pkg.
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output arpc_cmd_t cmd
);

    arpc_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                // hold until the output register is free or draining
                if (!out_valid_reg || m_tready)
                begin
                    cmd.resolve    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

### rtl/arpc_datapath.sv
// Table, request latch, match vectors and result register of the ARP cache.
// Depends on arpc_pkg.
module arpc_datapath
    import arpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  arpc_cmd_t         cmd,
    input  logic              in_func,
    input  logic [OP_W-1:0]   in_op,
    input  logic [IP_W-1:0]   in_ip,
    input  logic [MAC_W-1:0]  in_mac,
    output logic [STAT_W-1:0] status,
    output logic              found,
    output logic [MAC_W-1:0]  mac_out
);

    logic [IP_W-1:0]    entry_ip_reg  [ENTRIES];
    logic [MAC_W-1:0]   entry_mac_reg [ENTRIES];

    logic               req_func_reg;
    logic [OP_W-1:0]    req_op_reg;
    logic [IP_W-1:0]    req_ip_reg;
    logic [MAC_W-1:0]   req_mac_reg;

    logic [ENTRIES-1:0] match_vec_reg, match_vec_next;
    logic [ENTRIES-1:0] free_vec_reg, free_vec_next;

    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic               out_found_reg, out_found_next;
    logic [MAC_W-1:0]   out_mac_reg, out_mac_next;

    logic [IDX_W-1:0]   hit_idx, free_idx;
    logic               hit_any, free_any, learn_ok;

    // latch request beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_func_reg <= in_func;
            req_op_reg   <= in_op;
            req_ip_reg   <= in_ip;
            req_mac_reg  <= in_mac;
        end
    end

    // compare all slots against the request and against zero
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec_next[i] = (entry_ip_reg[i] == req_ip_reg);
            free_vec_next[i]  = (entry_ip_reg[i] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            match_vec_reg <= match_vec_next;
            free_vec_reg  <= free_vec_next;
        end
    end

    assign hit_any  = |match_vec_reg;
    assign free_any = |free_vec_reg;
    assign hit_idx  = first_set(match_vec_reg);
    assign free_idx = first_set(free_vec_reg);
    assign learn_ok = (req_func_reg == FUNC_LEARN) && (req_op_reg == OP_REPLY) && free_any;

    always_comb
    begin
        out_found_next = 1'b0;
        out_mac_next   = '0;
        if (req_func_reg == FUNC_LOOKUP)
        begin
            out_status_next = STAT_LOOKUP;
            out_found_next  = hit_any;
            if (hit_any)
            begin
                out_mac_next = entry_mac_reg[hit_idx];
            end
        end
        else if (req_op_reg != OP_REPLY)
        begin
            out_status_next = STAT_IGNORED;
        end
        else if (free_any)
        begin
            out_status_next = STAT_LEARNED;
        end
        else
        begin
            out_status_next = STAT_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_mac_reg    <= out_mac_next;
        end
    end

    // table: cleared to zero at reset, one slot written per learned reply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_ip_reg[i]  <= '0;
                entry_mac_reg[i] <= '0;
            end
        end
        else if (cmd.resolve && learn_ok)
        begin
            entry_ip_reg[free_idx]  <= req_ip_reg;
            entry_mac_reg[free_idx] <= req_mac_reg;
        end
    end

    assign status  = out_status_reg;
    assign found   = out_found_reg;
    assign mac_out = out_mac_reg;

endmodule

### rtl/arp_reply_learning_cache_top.sv
// ARP reply learning cache: 16-slot IP-to-MAC table, learn replies, look up IPs.
// Each item passes accept, slot compare and resolve/write in turn; a new item
//   is accepted only after the previous one resolves, and the resolve step
//   waits while an earlier result beat is still not taken.
// Reset: rst_n asynchronous, active low; clears the table to zero (all free)
//   and the controller to idle. No clearing pass is needed.
// Depends on arpc_pkg, arpc_ctrl and arpc_datapath.
module arp_reply_learning_cache_top
    import arpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] arp_operation, [47:16] ip_addr,
                                           // [95:48] mac_addr
    input  logic                 s_tuser,  // [0] func: 0 learn, 1 lookup
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [0] found, [48:1] mac_out, [55:49] zero
    output logic [STAT_W-1:0]    m_tuser   // [1:0] status
);

    arpc_cmd_t          cmd;
    logic               found;
    logic [MAC_W-1:0]   mac_out;

    // Controller: walks each item through compare and resolve, owns the
    // output valid flag so a new beat can be taken while a result waits.
    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: table registers, registered match/free vectors, priority
    // select of the lowest slot, and the result register.
    arpc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_func (s_tuser),
        .in_op   (s_tdata[OP_W-1:0]),
        .in_ip   (s_tdata[OP_W+IP_W-1:OP_W]),
        .in_mac  (s_tdata[OP_W+IP_W+MAC_W-1:OP_W+IP_W]),
        .status  (m_tuser),
        .found   (found),
        .mac_out (mac_out)
    );

    // pack result beat, pad to whole bytes
    assign m_tdata = {{(M_TDATA_W - MAC_W - 1){1'b0}}, mac_out, found};

endmodule

### rtl/arpc_checker.sv
// Port-level checks for the ARP cache, bound to the top level.
// Depends on arpc_pkg and arp_reply_learning_cache_top_defines.svh.
`include "arp_reply_learning_cache_top_defines.svh"

module arpc_checker
    import arpc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]    m_tuser
);

    `ARPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    `ARPC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second beat taken while an item is in work")
    `ARPC_ASSERT_NOW(a_found_on_lookup, m_tvalid && m_tdata[0], m_tuser == STAT_LOOKUP, "hit flagged on a learn result")
    `ARPC_ASSERT_NOW(a_learn_clean, m_tvalid && (m_tuser != STAT_LOOKUP), m_tdata == '0, "learn result carries hit or MAC")
    `ARPC_ASSERT_NOW(a_miss_clean, m_tvalid && (m_tuser == STAT_LOOKUP) && !m_tdata[0], m_tdata == '0, "lookup miss carries a MAC")

endmodule

bind arp_reply_learning_cache_top arpc_checker u_arpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/arp_cache_checker.sv
// Checker for the ARP reply learning cache: watches both streams, predicts each result
// beat from its own copy of the IP-to-MAC table and compares field by field.
// Depends on arpc_pkg.
module arp_cache_checker
    import arpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0]    m_tuser,
    output int                   n_errors,
    output int                   n_awaited
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [MAC_W-1:0]  mac;
    } arp_result_t;

    logic [IP_W-1:0]  cache_ip  [ENTRIES];
    logic [MAC_W-1:0] cache_mac [ENTRIES];
    arp_result_t      awaited_results[$];

    // Apply one request to the table copy and return the result it must produce.
    function automatic arp_result_t cache_access(input logic func, input logic [OP_W-1:0] op,
                                                 input logic [IP_W-1:0] ip,
                                                 input logic [MAC_W-1:0] mac);
        arp_result_t res;
        res = '{status: STAT_LOOKUP, found: 1'b0, mac: '0};
        if (func == FUNC_LOOKUP)
        begin
            // lowest matching slot wins; IP zero matches a free slot
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!res.found && cache_ip[i] == ip)
                begin
                    res.found = 1'b1;
                    res.mac   = cache_mac[i];
                end
            end
            return res;
        end
        if (op != OP_REPLY)
        begin
            res.status = STAT_IGNORED;
            return res;
        end
        res.status = STAT_FULL;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (res.status == STAT_FULL && cache_ip[i] == '0)
            begin
                cache_ip[i]  = ip;
                cache_mac[i] = mac;
                res.status   = STAT_LEARNED;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        arp_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                cache_ip[i]  = '0;
                cache_mac[i] = '0;
            end
            awaited_results.delete();
            n_awaited = 0;
            n_errors  = 0;
        end
        else
        begin
            // retire the oldest expectation before queuing the new one
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d found %0d mac %h",
                           m_tuser, m_tdata[0], m_tdata[48:1]);
                    n_errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        n_errors++;
                    end
                    if (m_tdata[0] !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, m_tdata[0]);
                        n_errors++;
                    end
                    if (m_tdata[48:1] !== want.mac)
                    begin
                        $error("mac_out: expected %h, actual %h", want.mac, m_tdata[48:1]);
                        n_errors++;
                    end
                    if (m_tdata[55:49] !== '0)
                    begin
                        $error("tdata pad: expected %h, actual %h", 7'h0, m_tdata[55:49]);
                        n_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(cache_access(s_tuser, s_tdata[15:0],
                                                       s_tdata[47:16], s_tdata[95:48]));
            end
            n_awaited = awaited_results.size();
        end
    end

endmodule

### dv/tb_arp_reply_learning_cache_top.sv
// Testbench top for the ARP reply learning cache: drives request beats in bursts,
// stalls the result side, and reports the verdict from arp_cache_checker.
// Depends on arpc_pkg, arp_reply_learning_cache_top and arp_cache_checker.
module tb_arp_reply_learning_cache_top
    import arpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Random request count after the directed opening.
    localparam int N_RANDOM   = 750;
    // Watchdog: ~770 beats plus sender gaps, receiver stalls and the long hold-off
    // fit with a wide margin under this limit.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the single long result-side hold-off.
    localparam int HOLD_CYCLES = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [15:0] arp_operation, [47:16] ip_addr, [95:48] mac_addr
    logic                 s_tuser;   // [0] func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [0] found, [48:1] mac_out, [55:49] zero
    logic [STAT_W-1:0]    m_tuser;   // [1:0] status

    int n_errors;
    int n_awaited;
    int n_sent;
    int burst_left;
    int cycles;

    // IPs handed to the cache in reply beats; lookups draw mostly from here
    // so that hits keep coming once the table has content.
    logic [IP_W-1:0] known_ips[$];

    arp_reply_learning_cache_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    arp_cache_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .n_errors  (n_errors),
        .n_awaited (n_awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request beat. Inputs change on the falling edge only; the beat
    // counts as taken at the first rising edge that sees tready high. Between
    // bursts drop tvalid for a random gap, sometimes none at all.
    task automatic offer_beat(input logic func, input logic [OP_W-1:0] op,
                              input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            // now and then a long burst, so stretches without idling occur
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {mac, ip, op};
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // Result side: stall in modes of random length (always ready, coin flip,
    // mostly stalled, fixed two-of-three pattern). Once enough beats have gone
    // in, hold tready low for a long stretch so the block backs up and stalls
    // its request side while the sender keeps offering.
    initial
    begin
        int mode;
        int len;
        int tick;
        bit hold_done;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 80);
            repeat (len)
            begin
                @(negedge clk);
                if (!hold_done && n_sent >= 60)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_arp_reply_learning_cache_top: errors");
        $finish;
    end

    initial
    begin
        int               pick;
        logic [OP_W-1:0]  op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = FUNC_LEARN;
        n_sent     = 0;
        burst_left = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening. On an empty table every slot is free, so a lookup
        // of IP zero hits slot 0 with a zero MAC; all ones misses.
        offer_beat(FUNC_LOOKUP, 16'h0000, 32'h0000_0000, 48'h0);
        offer_beat(FUNC_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        // Non-reply operations are ignored, including the byte-swapped reply code.
        offer_beat(FUNC_LEARN, 16'h0000, 32'h0A00_0001, 48'h0000_0000_0001);
        offer_beat(FUNC_LEARN, 16'h0001, 32'h0A00_0002, 48'h0000_0000_0002);
        offer_beat(FUNC_LEARN, 16'h0003, 32'h0A00_0003, 48'h0000_0000_0003);
        offer_beat(FUNC_LEARN, 16'h0200, 32'h0A00_0004, 48'h0000_0000_0004);
        offer_beat(FUNC_LEARN, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        // Learning IP zero writes the MAC into slot 0 but leaves it free;
        // the next lookup of zero returns that MAC.
        offer_beat(FUNC_LEARN, OP_REPLY, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        offer_beat(FUNC_LOOKUP, 16'h0002, 32'h0000_0000, 48'h0);
        // Real reply fills slot 0; zero now matches slot 1 (MAC still zero).
        offer_beat(FUNC_LEARN, OP_REPLY, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
        offer_beat(FUNC_LOOKUP, 16'h0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        // Lookup ignores the operation field.
        offer_beat(FUNC_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 48'h0);
        // Duplicate IP takes another slot; lookups keep returning the lower one.
        offer_beat(FUNC_LEARN, OP_REPLY, 32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
        offer_beat(FUNC_LOOKUP, OP_REPLY, 32'hFFFF_FFFF, 48'h5555_5555_5555);
        offer_beat(FUNC_LEARN, OP_REPLY, 32'h0000_0001, 48'h0000_0000_0001);
        offer_beat(FUNC_LOOKUP, 16'h0000, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);
        offer_beat(FUNC_LOOKUP, 16'h0000, 32'h0000_0002, 48'h0);
        offer_beat(FUNC_LEARN, OP_REPLY, 32'h8000_0000, 48'h8000_0000_0000);
        offer_beat(FUNC_LOOKUP, 16'h0000, 32'h8000_0000, 48'h0);
        offer_beat(FUNC_LOOKUP, 16'h0000, 32'h7FFF_FFFF, 48'h0);
        known_ips.push_back(32'hFFFF_FFFF);
        known_ips.push_back(32'h0000_0001);
        known_ips.push_back(32'h8000_0000);

        // Random part. Table-filling replies are rare so the table fills around
        // the middle of the run: lookups see it grow, then table-full drops
        // dominate the reply traffic for the rest.
        for (int k = 0; k < N_RANDOM; k++)
        begin
            pick = $urandom_range(0, 99);
            op   = 16'($urandom);
            ip   = $urandom;
            mac  = {16'($urandom), 32'($urandom)};
            if (pick < 3)
            begin
                // new reply, sometimes a duplicate of an IP already stored
                if ($urandom_range(0, 4) == 0)
                begin
                    ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
                end
                else if (ip == '0)
                begin
                    ip = 32'h0000_0100;
                end
                known_ips.push_back(ip);
                offer_beat(FUNC_LEARN, OP_REPLY, ip, mac);
            end
            else if (pick < 6)
            begin
                offer_beat(FUNC_LEARN, OP_REPLY, '0, mac);
            end
            else if (pick < 26)
            begin
                // near misses of the reply code, then arbitrary codes
                if (pick < 12)
                begin
                    op = OP_REPLY ^ (16'd1 << $urandom_range(0, 15));
                end
                else if (op == OP_REPLY)
                begin
                    op = ~op;
                end
                offer_beat(FUNC_LEARN, op, ip, mac);
            end
            else if (pick < 86)
            begin
                offer_beat(FUNC_LOOKUP, op, known_ips[$urandom_range(0, known_ips.size() - 1)],
                           mac);
            end
            else if (pick < 93)
            begin
                offer_beat(FUNC_LOOKUP, op, '0, mac);
            end
            else
            begin
                offer_beat(FUNC_LOOKUP, op, ip, mac);
            end
        end

        // Drain: drop tvalid, wait for every expected result, then keep the clock
        // running past the block's latency to catch stray beats.
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (n_awaited == 0);
        repeat (20) @(posedge clk);

        if (n_errors == 0)
        begin
            $display("tb_arp_reply_learning_cache_top: clean");
        end
        else
        begin
            $display("tb_arp_reply_learning_cache_top: errors");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_datapath.sv
rtl/arp_reply_learning_cache_top.sv
rtl/arpc_checker.sv
dv/arp_cache_checker.sv
dv/tb_arp_reply_learning_cache_top.sv
